>>> rtl/bcd_pkg.sv
// Package with shared constants, types and arithmetic helpers of the current deposition block.
package bcd_pkg;
  localparam int MaxCells = 64;
  localparam int Side     = MaxCells + 1;
  localparam int Nodes    = Side * Side;
  localparam int AddrW    = $clog2(Nodes);
  localparam int CellW    = $clog2(MaxCells + 1);
  localparam int AccW     = 48;
  localparam int DataW    = 3 * AccW;
  localparam int CfgIdxW  = 3;

  localparam logic [1:0] OpClear   = 2'd0;
  localparam logic [1:0] OpDeposit = 2'd1;
  localparam logic [1:0] OpFold    = 2'd2;
  localparam logic [1:0] OpRead    = 2'd3;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StOutside = 2'd1;
  localparam logic [1:0] StSat     = 2'd2;

  localparam logic [CfgIdxW-1:0] RegOriginX = 3'd0;
  localparam logic [CfgIdxW-1:0] RegOriginY = 3'd1;
  localparam logic [CfgIdxW-1:0] RegInvW    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegInvH    = 3'd3;
  localparam logic [CfgIdxW-1:0] RegInvA    = 3'd4;
  localparam logic [CfgIdxW-1:0] RegCellsX  = 3'd5;
  localparam logic [CfgIdxW-1:0] RegCellsY  = 3'd6;

  localparam logic signed [AccW-1:0] LimHi = {1'b0, {(AccW-1){1'b1}}};
  localparam logic signed [AccW-1:0] LimLo = {1'b1, {(AccW-1){1'b0}}};

  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] charge;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic [6:0]         node_x;
    logic [6:0]         node_y;
  } item_t;

  typedef struct packed {
    logic signed [AccW-1:0] cur_x;
    logic signed [AccW-1:0] cur_y;
    logic signed [AccW-1:0] cur_z;
    logic [1:0]             status;
  } result_t;

  // Saturate a 50-bit signed value into the accumulator range.
  function automatic logic [AccW:0] sat48(input logic signed [AccW+1:0] v);
    logic [AccW:0] r;
    if (v > $signed({{2{LimHi[AccW-1]}}, LimHi})) r = {1'b1, LimHi};
    else if (v < $signed({{2{LimLo[AccW-1]}}, LimLo})) r = {1'b1, LimLo};
    else r = {1'b0, v[AccW-1:0]};
    return r;
  endfunction

  function automatic logic [6:0] eff_cells(input logic [6:0] c);
    logic [6:0] r;
    if (c == 7'd0) r = 7'd1;
    else if (c > 7'(MaxCells)) r = 7'(MaxCells);
    else r = c;
    return r;
  endfunction
endpackage

>>> rtl/bcd_stream_if.sv
// Valid/ready channel interface carrying one payload.
interface bcd_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/bcd_ram.sv
// Generic single-port synchronous RAM with registered read.
module bcd_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end
endmodule

>>> rtl/bilinear_current_deposition_top.sv
// Top level of the cloud-in-cell current deposition engine.
//
//  channel  role    payload                                   transaction
//  in_if    sink    op, pos, charge, vel, node_x, node_y       valid & ready
//  out_if   source  cur_x, cur_y, cur_z, status                valid & ready
//  cfg      write   cfg_we_i, cfg_idx_i, cfg_data_i            cfg_we_i
//
// One item at a time through a single-port grid memory (one read or one write a cycle).
// Deposit: locate the cell, compute the three currents, then for each of four nodes
// the six weighted products, one read and one write.
// Clear: one node per cycle, all 4225 nodes. Fold: per pair, read both, add, write both. Read: one node.
// After reset a clearing pass over all 4225 nodes runs before the first item.
// The result waits in an output register; the next item is taken once it has left.
module bilinear_current_deposition_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  bcd_stream_if.sink                 in_if,
  bcd_stream_if.source               out_if,
  input  logic                       cfg_we_i,
  input  logic [bcd_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [31:0]                cfg_data_i
);
  import bcd_pkg::*;

  localparam logic [3:0] SInit = 4'd0, SIdle = 4'd1, SClr = 4'd2, SLoc = 4'd3,
                         SCur = 4'd4, SNode = 4'd5, SFold = 4'd6, SRead = 4'd7,
                         SOut = 4'd8;

  logic signed [31:0] org_x_q, org_y_q;
  logic [31:0] inv_w_q, inv_h_q, inv_a_q;
  logic [6:0]  cx_q, cy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_x_q <= '0; org_y_q <= '0;
      inv_w_q <= 32'd65536; inv_h_q <= 32'd65536; inv_a_q <= 32'd65536;
      cx_q <= 7'd64; cy_q <= 7'd64;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegOriginX: org_x_q <= cfg_data_i;
        RegOriginY: org_y_q <= cfg_data_i;
        RegInvW:    inv_w_q <= cfg_data_i;
        RegInvH:    inv_h_q <= cfg_data_i;
        RegInvA:    inv_a_q <= cfg_data_i;
        RegCellsX:  cx_q <= cfg_data_i[6:0];
        RegCellsY:  cy_q <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // Shared multiply unit: floor(a*b/2^16) with a 48-bit signed and b unsigned 32,
  // done in two halves (the high product registered in mhi_q), saturated at the end.
  logic [3:0]  st_q, st_d;
  logic [4:0]  step_q;
  item_t       it_q;
  logic        sat_q;
  logic [1:0]  stat_q;
  logic signed [AccW-1:0] ma_q;
  logic [31:0] mb_q;
  logic signed [AccW+16:0] mhi_q;
  logic signed [AccW+17:0] acc;
  logic [AccW:0] msat;
  logic signed [AccW+17:0] lo_prod;

  // Saturate the full product sum into the accumulator range.
  function automatic logic [AccW:0] sat_wide(input logic signed [AccW+17:0] v);
    logic [AccW:0] r;
    if (v > $signed({{18{LimHi[AccW-1]}}, LimHi})) r = {1'b1, LimHi};
    else if (v < $signed({{18{LimLo[AccW-1]}}, LimLo})) r = {1'b1, LimLo};
    else r = {1'b0, v[AccW-1:0]};
    return r;
  endfunction

  assign lo_prod = ma_q * $signed({1'b0, mb_q[15:0]});
  assign acc = $signed({mhi_q[AccW+16], mhi_q}) + (lo_prod >>> 16);
  assign msat = sat_wide(acc);

  logic signed [AccW-1:0] cur_q [3];
  logic signed [AccW-1:0] tx_q, tmp_q;
  logic [15:0] fx_q, fy_q;
  logic [6:0]  ix_q, iy_q;
  logic [AddrW-1:0] addr_q, addr_b_q;
  logic        we;
  logic [AddrW-1:0] addr;
  logic [DataW-1:0] wdata, rdata, hold_q;
  logic [1:0]  node_q;
  logic [2:0]  sub_q;
  logic        fphase_q;
  logic [6:0]  fi_q;
  logic [6:0]  nx, ny;
  result_t     res_q;
  logic        out_v_q;

  assign nx = eff_cells(cx_q);
  assign ny = eff_cells(cy_q);

  bcd_ram #(.Width(DataW), .Depth(Nodes)) u_grid (
    .clk_i(clk_i), .we_i(we), .addr_i(addr), .wdata_i(wdata), .rdata_o(rdata)
  );

  assign in_if.ready = (st_q == SIdle) && !out_v_q;
  assign out_if.valid = out_v_q;
  assign out_if.data = res_q;

  // Weights for the current node.
  logic [16:0] wx, wy;
  always_comb begin
    wx = node_q[1] ? {1'b0, fx_q} : 17'h10000 - {1'b0, fx_q};
    wy = node_q[0] ? {1'b0, fy_q} : 17'h10000 - {1'b0, fy_q};
  end

  // Saturating add of two accumulator words.
  function automatic logic [AccW:0] sadd(input logic signed [AccW-1:0] a,
                                         input logic signed [AccW-1:0] b);
    return sat48(50'(a) + 50'(b));
  endfunction

  logic [AccW:0] s0, s1, s2;
  always_comb begin
    s0 = sadd(rdata[3*AccW-1:2*AccW], hold_q[3*AccW-1:2*AccW]);
    s1 = sadd(rdata[2*AccW-1:AccW], hold_q[2*AccW-1:AccW]);
    s2 = sadd(rdata[AccW-1:0], hold_q[AccW-1:0]);
  end

  always_comb begin
    we = 1'b0;
    addr = addr_q;
    wdata = {s0[AccW-1:0], s1[AccW-1:0], s2[AccW-1:0]};
    case (st_q)
      SInit, SClr: begin we = 1'b1; wdata = '0; end
      SNode: begin
        we = (sub_q == 3'd2);
      end
      SFold: begin
        addr = (sub_q == 3'd6 || sub_q == 3'd4) ? addr_q : addr_b_q;
        we = (sub_q == 3'd4) || (sub_q == 3'd5);
        wdata = hold_q;
      end
      default: ;
    endcase
  end

  always_comb begin
    st_d = st_q;
    case (st_q)
      SInit: if (addr_q == AddrW'(Nodes - 1)) st_d = SIdle;
      default: ;
    endcase
  end

  // Multiply helper: product of a with the upper 16 bits of b.
  function automatic logic signed [AccW+16:0] hi_part(input logic signed [AccW-1:0] a,
                                                      input logic [31:0] b);
    return a * $signed({1'b0, b[31:16]});
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SInit; addr_q <= '0; out_v_q <= 1'b0; step_q <= '0; sub_q <= '0;
      node_q <= '0; fphase_q <= 1'b0; fi_q <= '0; sat_q <= 1'b0; stat_q <= StOk;
    end else begin
      if (out_if.valid && out_if.ready) out_v_q <= 1'b0;
      case (st_q)
        SInit: begin
          addr_q <= addr_q + 1'b1;
          st_q <= st_d;
        end
        SIdle: if (in_if.valid && in_if.ready) begin
          it_q <= in_if.data;
          sat_q <= 1'b0; stat_q <= StOk; step_q <= '0; sub_q <= '0;
          case (in_if.data.op)
            OpClear: begin addr_q <= '0; st_q <= SClr; end
            OpDeposit: st_q <= SLoc;
            OpFold: begin fphase_q <= 1'b0; fi_q <= '0; st_q <= SFold; end
            OpRead: begin
              addr_q <= AddrW'(in_if.data.node_y * Side) + AddrW'(in_if.data.node_x);
              if (in_if.data.node_x > nx || in_if.data.node_y > ny) begin
                stat_q <= StOutside; st_q <= SOut;
              end else st_q <= SRead;
            end
            default: ;
          endcase
        end
        SClr: begin
          addr_q <= addr_q + 1'b1;
          if (addr_q == AddrW'(Nodes - 1)) st_q <= SOut;
        end
        SLoc: begin
          // Steps: x mul (0..2), y mul (2..4), then the cell check and split into index and fraction.
          step_q <= step_q + 1'b1;
          case (step_q)
            5'd0: begin
              ma_q <= 48'($signed({it_q.pos_x[31], it_q.pos_x}) - $signed({org_x_q[31], org_x_q}));
              mb_q <= inv_w_q; end
            5'd1: mhi_q <= hi_part(ma_q, mb_q);
            5'd2: begin
              if (msat[AccW]) sat_q <= 1'b1;
              tx_q <= msat[AccW-1:0];
              ma_q <= 48'($signed({it_q.pos_y[31], it_q.pos_y}) - $signed({org_y_q[31], org_y_q}));
              mb_q <= inv_h_q;
            end
            5'd3: mhi_q <= hi_part(ma_q, mb_q);
            5'd4: begin
              if ($signed(tx_q[AccW-1:16]) < 0 || tx_q[AccW-1:16] >= 32'(nx) ||
                  $signed(msat[AccW-1:16]) < 0 || msat[AccW-1:16] >= 32'(ny)) begin
                stat_q <= StOutside; st_q <= SOut;
              end else begin
                ix_q <= tx_q[22:16]; fx_q <= tx_q[15:0];
                iy_q <= msat[22:16]; fy_q <= msat[15:0];
                sat_q <= 1'b0;
                st_q <= SCur; step_q <= '0;
              end
            end
            default: ;
          endcase
        end
        SCur: begin
          // For k: product q*v (64 bits) floor >>16 then times inv_a.
          step_q <= step_q + 1'b1;
          case (step_q[1:0])
            2'd0: begin
              tmp_q <= 48'((64'(it_q.charge) * 64'(step_q[3:2] == 2'd0 ? it_q.vel_x :
                      step_q[3:2] == 2'd1 ? it_q.vel_y : it_q.vel_z)) >>> 16);
            end
            2'd1: begin ma_q <= tmp_q; mb_q <= inv_a_q; end
            2'd2: mhi_q <= hi_part(ma_q, mb_q);
            default: begin
              if (msat[AccW]) sat_q <= 1'b1;
              cur_q[step_q[3:2]] <= msat[AccW-1:0];
              if (step_q[3:2] == 2'd2) begin
                st_q <= SNode; node_q <= '0; sub_q <= '0; step_q <= '0;
              end
            end
          endcase
        end
        SNode: begin
          // sub 0: compute three weighted values (two muls each),
          // then sub 1 reads the node and sub 2 writes the sum back.
          step_q <= step_q + 1'b1;
          if (sub_q == 3'd0) begin
            case (step_q[1:0])
              2'd0: begin
                ma_q <= step_q[2] ? tmp_q : cur_q[step_q[4:3] == 2'd3 ? 2'd0 : step_q[4:3]];
                mb_q <= step_q[2] ? 32'(wy) : 32'(wx); end
              2'd1: mhi_q <= hi_part(ma_q, mb_q);
              2'd2: begin
                if (msat[AccW]) sat_q <= 1'b1;
                if (!step_q[2]) tmp_q <= msat[AccW-1:0];
                else case (step_q[4:3])
                  2'd0: hold_q[3*AccW-1:2*AccW] <= msat[AccW-1:0];
                  2'd1: hold_q[2*AccW-1:AccW] <= msat[AccW-1:0];
                  default: hold_q[AccW-1:0] <= msat[AccW-1:0];
                endcase
                if (step_q[4:2] == 3'd5) begin
                  sub_q <= 3'd1;
                  addr_q <= AddrW'((iy_q + 7'(node_q[0])) * Side) +
                            AddrW'(ix_q + 7'(node_q[1]));
                end
                step_q <= step_q + 5'd2;
              end
              default: ;
            endcase
          end else if (sub_q == 3'd1) sub_q <= 3'd2;
          else begin
            if (s0[AccW] || s1[AccW] || s2[AccW]) sat_q <= 1'b1;
            sub_q <= '0; step_q <= '0;
            node_q <= node_q + 1'b1;
            if (node_q == 2'd3) st_q <= SOut;
          end
        end
        SFold: begin
          // 0 set addresses, 6 read a, 1 read b and latch a, 2 add b, 4 write a, 5 write b.
          sub_q <= sub_q + 1'b1;
          case (sub_q)
            3'd0: begin
              if (!fphase_q) begin
                addr_q <= AddrW'(fi_q); addr_b_q <= AddrW'(ny * Side) + AddrW'(fi_q);
              end else begin
                addr_q <= AddrW'(fi_q * Side); addr_b_q <= AddrW'(fi_q * Side) + AddrW'(nx);
              end
              sub_q <= 3'd6;
            end
            3'd6: sub_q <= 3'd1;
            3'd1: hold_q <= rdata;
            3'd2: begin
              if (s0[AccW] || s1[AccW] || s2[AccW]) sat_q <= 1'b1;
              hold_q <= {s0[AccW-1:0], s1[AccW-1:0], s2[AccW-1:0]};
            end
            3'd3, 3'd4: ;
            default: begin
              sub_q <= '0;
              fi_q <= fi_q + 1'b1;
              if (fi_q == (fphase_q ? ny : nx)) begin
                fi_q <= '0;
                if (fphase_q) st_q <= SOut;
                fphase_q <= 1'b1;
              end
            end
          endcase
        end
        SRead: begin
          step_q <= step_q + 1'b1;
          if (step_q == 5'd1) begin
            res_q.cur_x <= rdata[3*AccW-1:2*AccW];
            res_q.cur_y <= rdata[2*AccW-1:AccW];
            res_q.cur_z <= rdata[AccW-1:0];
            res_q.status <= StOk;
            out_v_q <= 1'b1; st_q <= SIdle;
          end
        end
        SOut: begin
          res_q.cur_x <= '0; res_q.cur_y <= '0; res_q.cur_z <= '0;
          res_q.status <= (stat_q == StOutside) ? StOutside : (sat_q ? StSat : StOk);
          out_v_q <= 1'b1; st_q <= SIdle;
        end
        default: st_q <= SIdle;
      endcase
    end
  end
endmodule
